// ===== rtl/ssr_pkg.sv =====
package ssr_pkg;

    // Sizing of the accumulator store and of the sums.
    localparam int MAX_SUMS   = 1024;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths.
    localparam int ELEM_W      = 32;
    localparam int SUM_W       = 32;
    localparam int SUM_INDEX_W = 10;
    localparam int OUTER_W     = 24;
    localparam int MIDDLE_W    = 11;
    localparam int INNER_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - SUM_INDEX_W;

    // Slot index and the width used to compare middle counts against the store size.
    localparam int IDX_W   = (MAX_SUMS > 1) ? $clog2(MAX_SUMS) : 1;
    localparam int NMID_W  = (IDX_W + 1 > MIDDLE_W) ? IDX_W + 1 : MIDDLE_W;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OUTER  = 2'd0,
        REG_MIDDLE = 2'd1,
        REG_INNER  = 2'd2
    } reg_index_t;

    typedef logic signed [DATA_WIDTH-1:0] acc_t;

    // One classified word, handed from the front to the back.
    typedef struct packed {
        logic signed [ELEM_W-1:0] elem;
        logic [IDX_W-1:0]         slot;
        logic                     load;   // first touch of the slot in this tensor
        logic                     emit;   // this word completes the slot
        logic                     last;   // completed slot is the final one
    } cmd_t;

    // Wrapped accumulator to the 32-bit result field.
    function automatic logic signed [SUM_W-1:0] acc_to_sum(acc_t v);
        return SUM_W'(v);
    endfunction

endpackage

// ===== rtl/ssr_front.sv =====
module ssr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                in_valid,
    input  logic [ssr_pkg::ELEM_W-1:0]          in_elem,
    input  logic                                queue_ready,
    output logic                                push,
    output ssr_pkg::cmd_t                       push_cmd
);

    logic [ssr_pkg::OUTER_W-1:0]  outer_cnt_reg;
    logic [ssr_pkg::MIDDLE_W-1:0] middle_cnt_reg;
    logic [ssr_pkg::INNER_W-1:0]  inner_cnt_reg;

    logic [ssr_pkg::INNER_W-1:0]  inner_pos_reg,  inner_pos_next;
    logic [ssr_pkg::IDX_W-1:0]    middle_pos_reg, middle_pos_next;
    logic [ssr_pkg::OUTER_W-1:0]  outer_pos_reg,  outer_pos_next;

    logic [ssr_pkg::OUTER_W-1:0]  n_outer;
    logic [ssr_pkg::NMID_W-1:0]   n_mid;
    logic [ssr_pkg::INNER_W-1:0]  n_inner;
    logic [ssr_pkg::NMID_W-1:0]   mid_wide;
    logic [ssr_pkg::IDX_W-1:0]    slot;
    logic                         inner_end;
    logic                         outer_end;
    logic                         mid_end;
    logic                         cfg_hit;

    // A zero count acts as one; the middle count is capped at the store size.
    always_comb
    begin
        n_outer = (outer_cnt_reg == '0) ? ssr_pkg::OUTER_W'(1) : outer_cnt_reg;
        n_inner = (inner_cnt_reg == '0) ? ssr_pkg::INNER_W'(1) : inner_cnt_reg;
        if (middle_cnt_reg == '0)
            n_mid = ssr_pkg::NMID_W'(1);
        else if (ssr_pkg::NMID_W'(middle_cnt_reg) > ssr_pkg::NMID_W'(ssr_pkg::MAX_SUMS))
            n_mid = ssr_pkg::NMID_W'(ssr_pkg::MAX_SUMS);
        else
            n_mid = ssr_pkg::NMID_W'(middle_cnt_reg);
    end

    always_comb
    begin
        slot      = (ssr_pkg::NMID_W'(middle_pos_reg) >= n_mid) ? '0 : middle_pos_reg;
        mid_wide  = ssr_pkg::NMID_W'(slot) + ssr_pkg::NMID_W'(1);
        inner_end = ({1'b0, inner_pos_reg} + 1'b1) >= {1'b0, n_inner};
        outer_end = ({1'b0, outer_pos_reg} + 1'b1) >= {1'b0, n_outer};
        mid_end   = mid_wide >= n_mid;

        push              = in_valid && queue_ready;
        push_cmd.elem     = $signed(in_elem);
        push_cmd.slot     = slot;
        push_cmd.load     = (outer_pos_reg == '0) && (inner_pos_reg == '0);
        push_cmd.emit     = outer_end && inner_end;
        push_cmd.last     = mid_end;

        inner_pos_next  = inner_pos_reg + 1'b1;
        middle_pos_next = slot;
        outer_pos_next  = outer_pos_reg;
        if (inner_end)
        begin
            inner_pos_next = '0;
            if (mid_end)
            begin
                middle_pos_next = '0;
                outer_pos_next  = outer_end ? '0 : outer_pos_reg + 1'b1;
            end
            else
            begin
                middle_pos_next = ssr_pkg::IDX_W'(mid_wide);
            end
        end
    end

    assign cfg_hit = cfg_wr_en &&
                     (cfg_wr_index == ssr_pkg::REG_OUTER  ||
                      cfg_wr_index == ssr_pkg::REG_MIDDLE ||
                      cfg_wr_index == ssr_pkg::REG_INNER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_cnt_reg  <= ssr_pkg::OUTER_W'(1);
            middle_cnt_reg <= ssr_pkg::MIDDLE_W'(1);
            inner_cnt_reg  <= ssr_pkg::INNER_W'(1);
            inner_pos_reg  <= '0;
            middle_pos_reg <= '0;
            outer_pos_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            // Any write to a count register starts a new tensor.
            case (ssr_pkg::reg_index_t'(cfg_wr_index))
                ssr_pkg::REG_OUTER:  outer_cnt_reg  <= cfg_wr_data;
                ssr_pkg::REG_MIDDLE: middle_cnt_reg <= ssr_pkg::MIDDLE_W'(cfg_wr_data);
                ssr_pkg::REG_INNER:  inner_cnt_reg  <= cfg_wr_data;
                default:             outer_cnt_reg  <= outer_cnt_reg;
            endcase
            inner_pos_reg  <= '0;
            middle_pos_reg <= '0;
            outer_pos_reg  <= '0;
        end
        else if (push)
        begin
            inner_pos_reg  <= inner_pos_next;
            middle_pos_reg <= middle_pos_next;
            outer_pos_reg  <= outer_pos_next;
        end
    end

endmodule

// ===== rtl/ssr_queue.sv =====
module ssr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ssr_pkg::cmd_t  push_cmd,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output ssr_pkg::cmd_t  pop_cmd
);

    ssr_pkg::cmd_t                  store_reg [ssr_pkg::QUEUE_DEPTH];
    logic [ssr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ssr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ssr_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign push_ready = count_reg != ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == ssr_pkg::QPTR_W'(ssr_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == ssr_pkg::QPTR_W'(ssr_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("queue read while empty");

endmodule

// ===== rtl/ssr_back.sv =====
module ssr_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  ssr_pkg::cmd_t                           q_cmd,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [ssr_pkg::SUM_W-1:0]        out_sum,
    output logic [ssr_pkg::SUM_INDEX_W-1:0]         out_index,
    output logic                                    out_last
);

    ssr_pkg::acc_t                  acc_mem [ssr_pkg::MAX_SUMS];
    ssr_pkg::acc_t                  rdata_reg;

    logic                           s1_valid_reg;
    ssr_pkg::cmd_t                  s1_reg;

    logic                           byp_valid_reg;
    logic [ssr_pkg::IDX_W-1:0]      byp_slot_reg;
    ssr_pkg::acc_t                  byp_sum_reg;

    logic                           out_valid_reg;
    logic signed [ssr_pkg::SUM_W-1:0]   out_sum_reg;
    logic [ssr_pkg::SUM_INDEX_W-1:0]    out_index_reg;
    logic                           out_last_reg;

    logic                           s1_fire;
    ssr_pkg::acc_t                  acc_old;
    ssr_pkg::acc_t                  acc_new;

    // The slot's read is taken when the word enters the stage; the one write that can
    // land at that same edge is covered by the last-write record.
    always_comb
    begin
        s1_fire = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || out_ready);
        q_pop   = q_valid && (!s1_valid_reg || s1_fire);
        acc_old = (byp_valid_reg && byp_slot_reg == s1_reg.slot) ? byp_sum_reg : rdata_reg;
        acc_new = s1_reg.load ? ssr_pkg::acc_t'(s1_reg.elem)
                              : acc_old + ssr_pkg::acc_t'(s1_reg.elem);
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            acc_mem[s1_reg.slot] <= acc_new;
        if (q_pop)
            rdata_reg <= acc_mem[q_cmd.slot];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            s1_reg <= q_cmd;
        if (s1_fire)
        begin
            byp_slot_reg <= s1_reg.slot;
            byp_sum_reg  <= acc_new;
        end
        if (s1_fire && s1_reg.emit)
        begin
            out_sum_reg   <= ssr_pkg::acc_to_sum(acc_new);
            out_index_reg <= ssr_pkg::SUM_INDEX_W'(s1_reg.slot);
            out_last_reg  <= s1_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
                byp_valid_reg <= 1'b1;
            if (s1_fire && s1_reg.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;
    assign out_index = out_index_reg;
    assign out_last  = out_last_reg;

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.emit && out_valid_reg && !out_ready |=> s1_valid_reg)
        else $error("completed sum left the stage while the output was held");

    a_bypass_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> byp_valid_reg && byp_slot_reg == $past(s1_reg.slot))
        else $error("last-write record does not follow the write");

endmodule

// ===== rtl/strided_sum_reduce.sv =====
// strided_sum_reduce reduces a tensor of shape outer_count x middle_count x inner_count,
// streamed in row-major order one element per word, to middle_count sums: each sum adds
// every element that shares a middle index, wrapped to 32 bits. Results appear only
// during the last outer pass, one word per middle index in index order, each carrying its
// index and tlast on the final sum of the tensor. The block takes one element per clock
// cycle, held back only by output backpressure; that figure is set by the accumulator
// store, which does one read and one write per cycle through a single read-modify-write
// stage. An accepted element passes through the front classification, a four-entry
// queue, the accumulate stage and the output register. Counts of zero act as one and
// a middle count above 1024 acts as 1024. Writing any count register restarts the
// tensor; write the registers only while the block is idle.
module strided_sum_reduce (
    input  logic                                clk,
    input  logic                                rst_n,
    // Count registers: 0 outer_count, 1 middle_count, 2 inner_count.
    input  logic                                cfg_wr_en,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    // Element stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ssr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] element_value
    // Sum stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ssr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [31:0] sum_value,
                                                                // [41:32] sum_index, zero pad
    output logic                                m_axis_tlast    // last_sum
);

    logic                                   push;
    logic                                   push_ready;
    ssr_pkg::cmd_t                          push_cmd;
    logic                                   q_valid;
    logic                                   q_pop;
    ssr_pkg::cmd_t                          q_cmd;
    logic signed [ssr_pkg::SUM_W-1:0]       sum_value;
    logic [ssr_pkg::SUM_INDEX_W-1:0]        sum_index;

    // The front tracks the tensor position and tags each word with its slot and role.
    ssr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (s_axis_tvalid),
        .in_elem      (s_axis_tdata[ssr_pkg::ELEM_W-1:0]),
        .queue_ready  (push_ready),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    assign s_axis_tready = push_ready;

    // The queue lets the front keep accepting while the back is held by the output.
    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd)
    );

    // The back owns the accumulator store and the output register.
    ssr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_sum   (sum_value),
        .out_index (sum_index),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{ssr_pkg::OUT_PAD_W{1'b0}}, sum_index, sum_value};

endmodule

// ===== tb/strided_sum_reduce_checker.sv =====
`timescale 1ns / 1ps

module strided_sum_reduce_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_wr_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [ssr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [31:0] element_value
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [ssr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [31:0] sum_value,
                                                                // [41:32] sum_index, zero pad
    input  logic                                m_axis_tlast,   // last_sum
    output int                                  mismatches,
    output int                                  sums_pending,
    output int                                  sums_checked
);

    localparam int DW  = ssr_pkg::DATA_WIDTH;
    localparam int SW  = ssr_pkg::SUM_W;
    localparam int SIW = ssr_pkg::SUM_INDEX_W;

    typedef struct packed {
        logic [SW-1:0]  value;
        logic [SIW-1:0] index;
        logic           last;
    } sum_word_t;

    logic [DW-1:0]                 slot_sums [ssr_pkg::MAX_SUMS];
    logic [ssr_pkg::OUTER_W-1:0]   outer_reg;
    logic [ssr_pkg::MIDDLE_W-1:0]  middle_reg;
    logic [ssr_pkg::INNER_W-1:0]   inner_reg;
    int unsigned                   inner_pos;
    int unsigned                   middle_pos;
    int unsigned                   outer_pos;
    sum_word_t                     expected_sums [$];
    sum_word_t                     oldest;
    int                            fail_count = 0;
    int                            done_count = 0;
    int                            waiting = 0;

    assign mismatches   = fail_count;
    assign sums_pending = waiting;
    assign sums_checked = done_count;

    task automatic report(input string what);
        $display("%0t ns: checker error: %s", $time, what);
        fail_count++;
    endtask

    // A count of zero behaves as one; the middle count is also capped at the store size.
    function automatic int unsigned span(input int unsigned v, input int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : v;
    endfunction

    task automatic accumulate_element(input logic [ssr_pkg::ELEM_W-1:0] elem);
        int unsigned   n_outer;
        int unsigned   n_mid;
        int unsigned   n_inner;
        int unsigned   m;
        logic [DW-1:0] x;
        logic [DW-1:0] total;
        sum_word_t     w;
        n_outer = span(32'(outer_reg), 32'hFFFF_FFFF);
        n_mid   = span(32'(middle_reg), ssr_pkg::MAX_SUMS);
        n_inner = span(32'(inner_reg), 32'hFFFF_FFFF);
        m = middle_pos;
        if (m >= n_mid)
            m = 0;
        x = DW'($signed(elem));
        // The first element of a slot in the first outer pass loads it.
        if (outer_pos == 0 && inner_pos == 0)
            total = x;
        else
            total = slot_sums[m] + x;
        slot_sums[m] = total;
        if (outer_pos + 1 >= n_outer && inner_pos + 1 >= n_inner)
        begin
            w.value = SW'($signed(total));
            w.index = SIW'(m);
            w.last  = (m + 1 >= n_mid);
            expected_sums.push_back(w);
        end
        inner_pos++;
        if (inner_pos >= n_inner)
        begin
            inner_pos = 0;
            m++;
            if (m >= n_mid)
            begin
                m = 0;
                outer_pos++;
                if (outer_pos >= n_outer)
                    outer_pos = 0;
            end
        end
        middle_pos = m;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            outer_reg  = ssr_pkg::OUTER_W'(1);
            middle_reg = ssr_pkg::MIDDLE_W'(1);
            inner_reg  = ssr_pkg::INNER_W'(1);
            inner_pos  = 0;
            middle_pos = 0;
            outer_pos  = 0;
            expected_sums.delete();
        end
        else
        begin
            if (cfg_wr_en && cfg_wr_index inside {ssr_pkg::REG_OUTER, ssr_pkg::REG_MIDDLE,
                                                  ssr_pkg::REG_INNER})
            begin
                case (cfg_wr_index)
                    ssr_pkg::REG_OUTER:  outer_reg  = cfg_wr_data[ssr_pkg::OUTER_W-1:0];
                    ssr_pkg::REG_MIDDLE: middle_reg = cfg_wr_data[ssr_pkg::MIDDLE_W-1:0];
                    default:             inner_reg  = cfg_wr_data[ssr_pkg::INNER_W-1:0];
                endcase
                // Any valid write starts a new tensor.
                inner_pos  = 0;
                middle_pos = 0;
                outer_pos  = 0;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    report($sformatf("sum %h index %0d last %b with none expected",
                                     m_axis_tdata[SW-1:0], m_axis_tdata[SW +: SIW],
                                     m_axis_tlast));
                end
                else
                begin
                    oldest = expected_sums.pop_front();
                    done_count++;
                    if (m_axis_tdata[SW-1:0] !== oldest.value)
                        report($sformatf("index %0d: sum %h, expected %h", oldest.index,
                                         m_axis_tdata[SW-1:0], oldest.value));
                    if (m_axis_tdata[SW +: SIW] !== oldest.index)
                        report($sformatf("sum index %0d, expected %0d",
                                         m_axis_tdata[SW +: SIW], oldest.index));
                    if (m_axis_tlast !== oldest.last)
                        report($sformatf("index %0d: tlast %b, expected %b", oldest.index,
                                         m_axis_tlast, oldest.last));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                accumulate_element(s_axis_tdata[ssr_pkg::ELEM_W-1:0]);
        end
        waiting = expected_sums.size();
    end

endmodule

// ===== tb/strided_sum_reduce_test.sv =====
`timescale 1ns / 1ps

module strided_sum_reduce_test;

    // Cycles allowed after the last expected sum before a register write or the verdict.
    localparam int DRAIN_CYCLES = 10;
    // Length of the long output stall used to back the block up into its input.
    localparam int HOLD_CYCLES  = 80;
    // Random elements per idling mode.
    localparam int MODE_ITEMS   = 100;
    // Elements sent while the middle count register holds its largest value.
    localparam int CAP_ELEMENTS = 40;

    // Register index beyond the list: the block must ignore the write completely.
    localparam logic [ssr_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [ssr_pkg::ELEM_W-1:0] ELEM_MAX  = 32'h7FFF_FFFF;
    localparam logic [ssr_pkg::ELEM_W-1:0] ELEM_MIN  = 32'h8000_0000;
    localparam logic [ssr_pkg::ELEM_W-1:0] ELEM_ONES = 32'hFFFF_FFFF;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wr_en;
    logic [ssr_pkg::CFG_INDEX_W-1:0]     cfg_wr_index;
    logic [ssr_pkg::CFG_DATA_W-1:0]      cfg_wr_data;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [ssr_pkg::IN_TDATA_W-1:0]      s_axis_tdata;   // [31:0] element_value
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [ssr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;   // [31:0] sum_value,
                                                         // [41:32] sum_index, zero pad
    logic                                m_axis_tlast;   // last_sum

    // Idle percentages of the two sides, changed by the main sequence per mode.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // The main sequence bumps this to ask the receiver for one long stall.
    int hold_requests = 0;

    int elements_sent = 0;
    int reg_writes    = 0;
    int mismatches;
    int sums_pending;
    int sums_checked;

    // Mirror of the count registers, used only to size the random tensors.
    int unsigned cur_outer  = 1;
    int unsigned cur_middle = 1;
    int unsigned cur_inner  = 1;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    strided_sum_reduce i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The checker sees every register write and every word on both streams, keeps its
    // own copy of the accumulators and positions, and compares each sum in order.
    strided_sum_reduce_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .sums_pending  (sums_pending),
        .sums_checked  (sums_checked)
    );

    // Watchdog: far beyond the slowest correct run (several hundred elements, even under
    // the heaviest output stalls).
    initial
    begin
        #400000;
        $display("strided_sum_reduce_test: done, errors");
        $finish;
    end

    // Output side. Normally tready is random per cycle at the current idle rate. On a
    // hold request the receiver drops tready and keeps it low for HOLD_CYCLES, counted
    // here, while the sender keeps offering elements.
    initial
    begin
        int hold_served;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // All tasks below start and end on a falling edge, and the step they end on carries
    // no assignment, so the next task may drive a signal there without a second one.
    task automatic write_reg(input logic [ssr_pkg::CFG_INDEX_W-1:0] idx,
                             input int unsigned                     data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= ssr_pkg::CFG_DATA_W'(data);
        case (idx)
            ssr_pkg::REG_OUTER:  cur_outer  = data & 32'h00FF_FFFF;
            ssr_pkg::REG_MIDDLE: cur_middle = data & 32'h0000_07FF;
            ssr_pkg::REG_INNER:  cur_inner  = data & 32'h00FF_FFFF;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one element, idling first at the current rate, and hold it until accepted.
    // tvalid stays high afterwards so back-to-back elements need no extra edge.
    task automatic send_element(input logic [ssr_pkg::ELEM_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        elements_sent++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected sum has left the block. Elements that
    // make no sum may still be inside, hence the extra drain before any register write.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sums_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly full-range random values, with the sign and wrap extremes mixed in.
    function automatic logic [ssr_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(15))
            0:       return ELEM_MAX;
            1:       return ELEM_MIN;
            2:       return ELEM_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Elements in one tensor under the current counts, with zero and cap handling.
    function automatic int unsigned tensor_size();
        int unsigned o;
        int unsigned m;
        int unsigned i;
        o = (cur_outer == 0) ? 1 : cur_outer;
        i = (cur_inner == 0) ? 1 : cur_inner;
        m = (cur_middle == 0) ? 1 : cur_middle;
        if (m > ssr_pkg::MAX_SUMS)
            m = ssr_pkg::MAX_SUMS;
        return o * m * i;
    endfunction

    // One random setting of the counts followed by one or two whole tensors, or now
    // and then a tensor cut short, which the next register write must abandon.
    task automatic random_phase();
        int unsigned outer_v;
        int unsigned middle_v;
        int unsigned inner_v;
        int unsigned n_elems;
        outer_v = $urandom_range(3);
        inner_v = $urandom_range(3);
        if ($urandom_range(9) == 0)
        begin
            // A wider tensor now and then, kept short on the other axes.
            middle_v = $urandom_range(60, 13);
            outer_v  = 1;
            inner_v  = $urandom_range(2);
        end
        else
        begin
            middle_v = $urandom_range(12);
        end
        // Wide tensors always write the other two counts so that they stay short.
        if (middle_v > 12 || $urandom_range(3) != 0)
            write_reg(ssr_pkg::REG_OUTER, outer_v);
        write_reg(ssr_pkg::REG_MIDDLE, middle_v);
        if (middle_v > 12 || $urandom_range(3) != 0)
            write_reg(ssr_pkg::REG_INNER, inner_v);
        if ($urandom_range(7) == 0)
            write_reg(REG_SPARE, $urandom);
        if ($urandom_range(6) == 0)
            n_elems = $urandom_range(tensor_size(), 1);
        else
            n_elems = tensor_size() * $urandom_range(2, 1);
        repeat (n_elems) send_element(rand_elem());
        settle();
    endtask

    task automatic random_mode(input int n_elems);
        int start;
        start = elements_sent;
        while (elements_sent - start < n_elems)
            random_phase();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // First mode: the sender idles now and then, the receiver most of the time.
        send_idle_pct = 28;
        recv_idle_pct = 65;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Counts straight out of reset are all one, so every element is its own sum.
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        settle();

        // A 2 x 3 x 2 tensor. The first slot sums the largest positive value with
        // itself and the second the most negative one with minus one, so both wrap.
        write_reg(ssr_pkg::REG_OUTER, 2);
        write_reg(ssr_pkg::REG_MIDDLE, 3);
        write_reg(ssr_pkg::REG_INNER, 2);
        send_element(ELEM_MAX);
        send_element(ELEM_MAX);
        send_element(ELEM_MIN);
        send_element(ELEM_ONES);
        send_element('0);
        // Pause in the middle of the tensor until the block has drained, then write the
        // index past the register list: the positions must carry on where they were.
        settle();
        write_reg(REG_SPARE, 32'h00FF_FFFF);
        repeat (7) send_element(rand_elem());
        settle();

        // Zero in every count register behaves as one.
        write_reg(ssr_pkg::REG_OUTER, 0);
        write_reg(ssr_pkg::REG_MIDDLE, 0);
        write_reg(ssr_pkg::REG_INNER, 0);
        send_element(ELEM_ONES);
        send_element(1);
        send_element('0);
        settle();

        // Full-range outer count: elements go in but no sum can complete.
        write_reg(ssr_pkg::REG_OUTER, 32'h00FF_FFFF);
        write_reg(ssr_pkg::REG_MIDDLE, 2);
        write_reg(ssr_pkg::REG_INNER, 1);
        repeat (4) send_element(rand_elem());
        settle();

        // Same for the inner count; the write also drops the unfinished tensor above.
        write_reg(ssr_pkg::REG_OUTER, 1);
        write_reg(ssr_pkg::REG_INNER, 32'h00FF_FFFF);
        repeat (3) send_element(rand_elem());
        settle();
        write_reg(ssr_pkg::REG_INNER, 1);

        random_mode(MODE_ITEMS);

        // Second mode: roles swapped, the sender is now the slow side.
        send_idle_pct = 65;
        recv_idle_pct = 28;

        // All ones in the middle register keeps its low eleven bits and is capped at
        // the store size; every element still completes a sum at its own index.
        write_reg(ssr_pkg::REG_OUTER, 1);
        write_reg(ssr_pkg::REG_INNER, 1);
        write_reg(ssr_pkg::REG_MIDDLE, 32'h00FF_FFFF);
        repeat (CAP_ELEMENTS) send_element(rand_elem());
        settle();

        random_mode(MODE_ITEMS);

        // Third mode: neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Every element completes a sum, and the receiver stalls for a long stretch
        // while elements keep coming, so the internal queue fills and tready drops.
        write_reg(ssr_pkg::REG_OUTER, 1);
        write_reg(ssr_pkg::REG_MIDDLE, 8);
        write_reg(ssr_pkg::REG_INNER, 1);
        hold_requests++;
        repeat (30) send_element(rand_elem());
        settle();

        random_mode(MODE_ITEMS);

        $display("strided_sum_reduce_test: %0d elements, %0d register writes, %0d sums",
                 elements_sent, reg_writes, sums_checked);
        $display("covered zero, oversized and full-range counts, ignored index, long stall");
        if (mismatches == 0 && sums_pending == 0)
        begin
            $display("strided_sum_reduce_test: done, clean");
        end
        else
        begin
            if (sums_pending != 0)
                $display("%0d expected sums never arrived", sums_pending);
            $display("strided_sum_reduce_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ssr_pkg.sv
rtl/ssr_front.sv
rtl/ssr_queue.sv
rtl/ssr_back.sv
rtl/strided_sum_reduce.sv
tb/strided_sum_reduce_checker.sv
tb/strided_sum_reduce_test.sv
